// ===== src/mfqs_pkg.sv =====
`default_nettype none

package mfqs_pkg;

    // scheduler sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int NUM_LEVELS  = 4;

    // fixed field widths of the item and result
    localparam int ID_BITS         = 16;
    localparam int LEVEL_BITS      = 2;
    localparam int FIELD_TIME_BITS = 16;
    localparam int OUTCOME_BITS    = 3;
    localparam int QUANTUM_BITS    = 16;

    // derived sizes
    localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS = LEVEL_BITS + PTR_BITS;
    localparam int MEM_DEPTH = NUM_LEVELS << PTR_BITS;
    localparam int CMP_BITS  = (TIME_BITS > QUANTUM_BITS) ? TIME_BITS : QUANTUM_BITS;

    // configuration port
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    typedef logic [LEVEL_BITS-1:0]   level_t;
    typedef logic [PTR_BITS-1:0]     ptr_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;
    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [TIME_BITS-1:0]    time_val_t;
    typedef logic [QUANTUM_BITS-1:0] quantum_t;

    typedef logic [NUM_LEVELS-1:0][QUANTUM_BITS-1:0] quantum_array_t;

    localparam quantum_array_t QUANTUM_RESET = {16'd8, 16'd4, 16'd2, 16'd1};

    localparam level_t LAST_LEVEL = level_t'(NUM_LEVELS - 1);

    // request codes
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_ADDED     = 3'd0,
        OUT_FULL      = 3'd1,
        OUT_DEMOTED   = 3'd2,
        OUT_COMPLETED = 3'd3,
        OUT_IDLE      = 3'd4
    } outcome_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SERVE = 1'b1
    } state_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        time_val_t          remain;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic add;
        logic lookup;
        logic idle;
        logic serve;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic work_pending;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/mfqs_regs.sv =====
`default_nettype none

module mfqs_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mfqs_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [mfqs_pkg::PDATA_BITS-1:0]  pwdata,
    output logic                                  pready,
    output logic [mfqs_pkg::PDATA_BITS-1:0]       prdata,
    output mfqs_pkg::quantum_array_t              quantum
);
    import mfqs_pkg::*;

    quantum_array_t quantum_reg;
    quantum_array_t quantum_next;
    level_t         reg_index;
    logic           wr_en;

    assign reg_index = paddr[PADDR_BITS-1:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        quantum_next = quantum_reg;
        if (wr_en)
        begin
            quantum_next[reg_index] = pwdata[QUANTUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            quantum_reg <= quantum_next;
        end
    end

    assign prdata  = PDATA_BITS'(quantum_reg[reg_index]);
    assign quantum = quantum_reg;

endmodule

`default_nettype wire

// ===== src/mfqs_ctrl.sv =====
`default_nettype none

module mfqs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 req_type,
    input  wire mfqs_pkg::dp_status_t status,
    output logic                      busy,
    output mfqs_pkg::ctrl_cmd_t       cmd
);
    import mfqs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start & ~busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_RUN) && status.work_pending)
                begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.add    = start & (req_type == REQ_ADD);
                cmd.lookup = start & (req_type == REQ_RUN) & status.work_pending;
                cmd.idle   = start & (req_type == REQ_RUN) & ~status.work_pending;
            end
            ST_SERVE:
            begin
                busy      = 1'b1;
                cmd.serve = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mfqs_datapath.sv =====
`default_nettype none

module mfqs_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mfqs_pkg::ctrl_cmd_t                   cmd,
    input  wire mfqs_pkg::quantum_array_t              quantum,
    input  wire logic [mfqs_pkg::ID_BITS-1:0]          process_id,
    input  wire logic [mfqs_pkg::LEVEL_BITS-1:0]       start_level,
    input  wire logic [mfqs_pkg::FIELD_TIME_BITS-1:0]  burst_time,
    output mfqs_pkg::dp_status_t                       status,
    output logic                                       done,
    output logic [mfqs_pkg::OUTCOME_BITS-1:0]          outcome,
    output logic [mfqs_pkg::ID_BITS-1:0]               served_id,
    output logic [mfqs_pkg::LEVEL_BITS-1:0]            served_level,
    output logic [mfqs_pkg::FIELD_TIME_BITS-1:0]       time_left
);
    import mfqs_pkg::*;

    // per-level ring pointers and occupancy
    ptr_t   head_reg  [NUM_LEVELS];
    ptr_t   head_next [NUM_LEVELS];
    ptr_t   tail_reg  [NUM_LEVELS];
    ptr_t   tail_next [NUM_LEVELS];
    cnt_t   count_reg [NUM_LEVELS];
    cnt_t   count_next[NUM_LEVELS];
    cnt_t   total_reg;
    cnt_t   total_next;

    // entry store, one ring per level
    entry_t mem [MEM_DEPTH];
    entry_t rd_data_reg;
    level_t sel_level_reg;

    logic   mem_we;
    addr_t  mem_waddr;
    entry_t mem_wdata;
    addr_t  mem_raddr;

    // result registers
    logic                       done_reg;
    logic                       done_next;
    outcome_t                   outcome_reg;
    outcome_t                   outcome_next;
    logic [ID_BITS-1:0]         id_reg;
    logic [ID_BITS-1:0]         id_next;
    level_t                     level_reg;
    level_t                     level_next;
    logic [FIELD_TIME_BITS-1:0] time_reg;
    logic [FIELD_TIME_BITS-1:0] time_next;

    level_t                pick;
    logic                  found;
    logic                  full;
    time_val_t             burst_fit;
    logic [CMP_BITS-1:0]   t_wide;
    logic [CMP_BITS-1:0]   q_wide;
    logic [CMP_BITS-1:0]   rem_wide;
    time_val_t             rem;
    level_t                demote_level;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    // highest non-empty level
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found = 1'b1;
                pick  = level_t'(l);
            end
        end
    end

    assign status.work_pending = found;
    assign full                = (total_reg == cnt_t'(QUEUE_DEPTH));
    assign burst_fit           = TIME_BITS'(burst_time);
    assign mem_raddr           = {pick, head_reg[pick]};

    // slice subtraction, saturating at zero
    assign t_wide       = CMP_BITS'(rd_data_reg.remain);
    assign q_wide       = CMP_BITS'(quantum[sel_level_reg]);
    assign rem_wide     = (t_wide > q_wide) ? (t_wide - q_wide) : '0;
    assign rem          = TIME_BITS'(rem_wide);
    assign demote_level = (sel_level_reg == LAST_LEVEL) ? sel_level_reg
                                                        : sel_level_reg + level_t'(1);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        done_next    = 1'b0;
        outcome_next = outcome_reg;
        id_next      = id_reg;
        level_next   = level_reg;
        time_next    = time_reg;

        priority if (cmd.add)
        begin
            done_next  = 1'b1;
            id_next    = process_id;
            level_next = start_level;
            time_next  = FIELD_TIME_BITS'(burst_fit);
            if (full)
            begin
                outcome_next = OUT_FULL;
            end
            else
            begin
                outcome_next            = OUT_ADDED;
                mem_we                  = 1'b1;
                mem_waddr               = {start_level, tail_reg[start_level]};
                mem_wdata.id            = process_id;
                mem_wdata.remain        = burst_fit;
                tail_next[start_level]  = ptr_inc(tail_reg[start_level]);
                count_next[start_level] = count_reg[start_level] + cnt_t'(1);
                total_next              = total_reg + cnt_t'(1);
            end
        end
        else if (cmd.idle)
        begin
            done_next    = 1'b1;
            outcome_next = OUT_IDLE;
            id_next      = '0;
            level_next   = '0;
            time_next    = '0;
        end
        else if (cmd.serve)
        begin
            done_next                 = 1'b1;
            id_next                   = rd_data_reg.id;
            level_next                = sel_level_reg;
            time_next                 = FIELD_TIME_BITS'(rem);
            head_next[sel_level_reg]  = ptr_inc(head_reg[sel_level_reg]);
            count_next[sel_level_reg] = count_reg[sel_level_reg] - cnt_t'(1);
            if (rem == '0)
            begin
                outcome_next = OUT_COMPLETED;
                total_next   = total_reg - cnt_t'(1);
            end
            else
            begin
                // requeue at the tail of the next level down (the last level requeues onto itself)
                outcome_next             = OUT_DEMOTED;
                mem_we                   = 1'b1;
                mem_waddr                = {demote_level, tail_reg[demote_level]};
                mem_wdata.id             = rd_data_reg.id;
                mem_wdata.remain         = rem;
                tail_next[demote_level]  = ptr_inc(tail_reg[demote_level]);
                count_next[demote_level] = count_next[demote_level] + cnt_t'(1);
            end
        end
        else
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.lookup)
        begin
            rd_data_reg   <= mem[mem_raddr];
            sel_level_reg <= pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        id_reg      <= id_next;
        level_reg   <= level_next;
        time_reg    <= time_next;
    end

    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign served_id    = id_reg;
    assign served_level = level_reg;
    assign time_left    = time_reg;

endmodule

`default_nettype wire

// ===== src/multilevel_feedback_queue_scheduler_top.sv =====
`default_nettype none

// four-level feedback scheduler. start with busy low transfers one request:
// req_type add queues (process_id, burst_time) at the tail of start_level,
// req_type run serves the head of the highest non-empty level, subtracts that
// level's quantum and either completes the process or requeues it one level
// down (level 3 requeues onto itself). every request yields exactly one
// result, shown on the result ports for a single cycle with done high; the
// receiver cannot stall, so it must take the transfer in that cycle. an add,
// or a run that finds every level empty, is handled in the cycle it is taken
// and the next request may follow right away; a run that finds work holds
// busy high in a serve state, because the head entry is read from the entry
// memory when the run is taken and the requeue write and pointer update
// happen in the serve state. the result appears the cycle after the request
// finishes. the entry memory needs no clearing after reset: only occupied
// slots are ever read. quantum registers sit on the apb port at byte
// addresses 0, 4, 8 and 12 and may be changed only while no request is open.

module multilevel_feedback_queue_scheduler_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // apb configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mfqs_pkg::PADDR_BITS-1:0]       paddr,
    input  wire logic [mfqs_pkg::PDATA_BITS-1:0]       pwdata,
    output logic                                       pready,
    output logic [mfqs_pkg::PDATA_BITS-1:0]            prdata,
    // request
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  req_type,
    input  wire logic [mfqs_pkg::ID_BITS-1:0]          process_id,
    input  wire logic [mfqs_pkg::LEVEL_BITS-1:0]       start_level,
    input  wire logic [mfqs_pkg::FIELD_TIME_BITS-1:0]  burst_time,
    // result
    output logic                                       done,
    output logic [mfqs_pkg::OUTCOME_BITS-1:0]          outcome,
    output logic [mfqs_pkg::ID_BITS-1:0]               served_id,
    output logic [mfqs_pkg::LEVEL_BITS-1:0]            served_level,
    output logic [mfqs_pkg::FIELD_TIME_BITS-1:0]       time_left
);
    import mfqs_pkg::*;

    quantum_array_t quantum;   // per-level time slice
    ctrl_cmd_t      cmd;       // controller commands for this cycle
    dp_status_t     status;    // any level holding work

    // quantum registers
    mfqs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .quantum (quantum)
    );

    // request sequencing: idle, or serving a run
    mfqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    // queue pointers, entry memory, slice arithmetic and result registers
    mfqs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .quantum      (quantum),
        .process_id   (process_id),
        .start_level  (start_level),
        .burst_time   (burst_time),
        .status       (status),
        .done         (done),
        .outcome      (outcome),
        .served_id    (served_id),
        .served_level (served_level),
        .time_left    (time_left)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

// checks the four-level feedback scheduler against an in-bench predictor.
// requests go in over start/busy and every accepted transfer is predicted in
// order; each done strobe is compared field by field with the oldest
// prediction. quantum registers are rewritten between phases over the apb
// port, always with nothing in flight.

module testbench;

    import mfqs_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 125;
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE       = 6;

    // quantum register indexes, byte address is 4 * index
    typedef enum int {
        REG_QUANTUM0 = 0,
        REG_QUANTUM1 = 1,
        REG_QUANTUM2 = 2,
        REG_QUANTUM3 = 3
    } quantum_reg_t;

    // one predicted result
    typedef struct {
        outcome_t           kind;
        logic [ID_BITS-1:0] pid;
        level_t             level;
        logic [15:0]        remain;
    } sched_result_t;

    // predictor plus the store of results still to come
    class sched_scoreboard;
        quantum_t           quantum [NUM_LEVELS];
        logic [ID_BITS-1:0] slot_id [NUM_LEVELS][QUEUE_DEPTH];
        time_val_t          slot_time [NUM_LEVELS][QUEUE_DEPTH];
        int                 head [NUM_LEVELS];
        int                 tail [NUM_LEVELS];
        int                 level_count [NUM_LEVELS];
        int                 held;
        sched_result_t      pending_results [$];
        int                 errors;

        function new();
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                quantum[l]     = QUANTUM_RESET[l];
                head[l]        = 0;
                tail[l]        = 0;
                level_count[l] = 0;
            end
            held   = 0;
            errors = 0;
        endfunction

        function void set_quantum(int idx, quantum_t value);
            quantum[idx] = value;
        endfunction

        function void enqueue_process(int l, logic [ID_BITS-1:0] pid, time_val_t t);
            slot_id[l][tail[l]]   = pid;
            slot_time[l][tail[l]] = t;
            tail[l]               = (tail[l] + 1) % QUEUE_DEPTH;
            level_count[l]++;
        endfunction

        // work out the result of one accepted request
        function void note_request(logic req, logic [ID_BITS-1:0] pid, level_t lvl,
                                   logic [15:0] burst);
            sched_result_t r;
            time_val_t     t;
            int            slot;
            int            nxt;
            bit            served;
            served = 0;
            if (req == REQ_ADD)
            begin
                r.pid    = pid;
                r.level  = lvl;
                r.remain = burst;
                if (held >= QUEUE_DEPTH)
                    r.kind = OUT_FULL;
                else
                begin
                    enqueue_process(int'(lvl), pid, time_val_t'(burst));
                    held++;
                    r.kind = OUT_ADDED;
                end
            end
            else
            begin
                r.kind   = OUT_IDLE;
                r.pid    = '0;
                r.level  = '0;
                r.remain = '0;
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    if (!served && level_count[l] != 0)
                    begin
                        served = 1;
                        slot   = head[l];
                        t      = slot_time[l][slot];
                        head[l] = (slot + 1) % QUEUE_DEPTH;
                        level_count[l]--;
                        t = (t > quantum[l]) ? time_val_t'(t - quantum[l]) : '0;
                        r.pid    = slot_id[l][slot];
                        r.level  = level_t'(l);
                        r.remain = 16'(t);
                        if (t == 0)
                        begin
                            held--;
                            r.kind = OUT_COMPLETED;
                        end
                        else
                        begin
                            // bottom level requeues onto itself
                            nxt = (l + 1 < NUM_LEVELS) ? l + 1 : NUM_LEVELS - 1;
                            enqueue_process(nxt, slot_id[l][slot], t);
                            r.kind = OUT_DEMOTED;
                        end
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUTCOME_BITS-1:0] kind, logic [ID_BITS-1:0] pid,
                                   level_t lvl, logic [15:0] remain);
            sched_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: outcome %0d id %h", kind, pid);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (kind !== e.kind)
            begin
                $error("outcome expected %0d actual %0d", e.kind, kind);
                errors++;
            end
            if (pid !== e.pid)
            begin
                $error("served_id expected %h actual %h", e.pid, pid);
                errors++;
            end
            if (lvl !== e.level)
            begin
                $error("served_level expected %0d actual %0d", e.level, lvl);
                errors++;
            end
            if (remain !== e.remain)
            begin
                $error("time_left expected %h actual %h", e.remain, remain);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_BITS-1:0]      paddr;
    logic [PDATA_BITS-1:0]      pwdata;
    logic                       pready;
    logic [PDATA_BITS-1:0]      prdata;
    logic                       start;
    logic                       busy;
    logic                       req_type;
    logic [ID_BITS-1:0]         process_id;
    logic [LEVEL_BITS-1:0]      start_level;
    logic [FIELD_TIME_BITS-1:0] burst_time;
    logic                       done;
    logic [OUTCOME_BITS-1:0]    outcome;
    logic [ID_BITS-1:0]         served_id;
    logic [LEVEL_BITS-1:0]      served_level;
    logic [FIELD_TIME_BITS-1:0] time_left;

    sched_scoreboard sb;
    int unsigned     cycle_count;

    multilevel_feedback_queue_scheduler_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .prdata       (prdata),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .process_id   (process_id),
        .start_level  (start_level),
        .burst_time   (burst_time),
        .done         (done),
        .outcome      (outcome),
        .served_id    (served_id),
        .served_level (served_level),
        .time_left    (time_left)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // monitor: check the result first, then predict a request transfer
    // taken at the same edge; a result never shares an edge with its own
    // request, so the order only keeps the queue tidy
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(outcome, served_id, level_t'(served_level), time_left);
            if (start && !busy)
                sb.note_request(req_type, process_id, level_t'(start_level), burst_time);
        end
    end

    // one request transfer; entered and left at a falling edge, start stays
    // high so back-to-back transfers need no gap
    task automatic send_request(logic req, logic [ID_BITS-1:0] pid,
                                logic [LEVEL_BITS-1:0] lvl, logic [15:0] burst);
        start       <= 1'b1;
        req_type    <= req;
        process_id  <= pid;
        start_level <= lvl;
        burst_time  <= burst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender gap, start held low for the requested length
    task automatic idle_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // hold the sender until every predicted result has come, then let the
    // block settle before anything else happens
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // apb write: setup cycle, access cycle, written when pready is seen,
    // then the bus returns to idle
    task automatic write_quantum(quantum_reg_t idx, logic [PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(int'(idx) * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_quantum(int'(idx), data[QUANTUM_BITS-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_quanta(quantum_t q0, quantum_t q1, quantum_t q2, quantum_t q3);
        // upper data bits are don't-care, so exercise them too
        write_quantum(REG_QUANTUM0, {16'($urandom), q0});
        write_quantum(REG_QUANTUM1, {16'($urandom), q1});
        write_quantum(REG_QUANTUM2, {16'($urandom), q2});
        write_quantum(REG_QUANTUM3, {16'($urandom), q3});
    endtask

    // mostly short bursts so processes finish, plus zero and extremes
    function automatic logic [15:0] pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        else if (r < 15)
            return 16'hffff;
        else if (r < 30)
            return 16'($urandom);
        else
            return 16'($urandom_range(1, 40));
    endfunction

    // short directed part, run with the reset quanta
    task automatic run_directed();
        logic [15:0] burst;
        // empty scheduler reports idle
        send_request(REQ_RUN, 16'h5a5a, 2'd3, 16'hffff);
        // zero burst is taken and completes on its first run
        send_request(REQ_ADD, 16'hffff, 2'd0, 16'h0000);
        send_request(REQ_RUN, 16'h0000, 2'd0, 16'h0000);
        send_request(REQ_ADD, 16'h0000, 2'd3, 16'hffff);
        send_request(REQ_ADD, 16'h1234, 2'd1, 16'h0001);
        // fill every slot across the levels
        for (int i = 0; i < QUEUE_DEPTH - 2; i++)
        begin
            burst = (i % 3 == 0) ? 16'hffff : 16'(i + 1);
            send_request(REQ_ADD, 16'(16'h8000 + i), 2'(i), burst);
        end
        // one more add with every slot taken is refused
        send_request(REQ_ADD, 16'hbeef, 2'd2, 16'h7fff);
        repeat (4) send_request(REQ_RUN, 16'($urandom), 2'($urandom), 16'($urandom));
    endtask

    // one random phase; blocks alternate between add-heavy and run-heavy so
    // the scheduler swings between full and idle
    task automatic run_random_phase(int ph, bit no_gaps);
        int add_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (ph == 3 && n == 60)
                wait_drained();
            if (!no_gaps && $urandom_range(0, 99) < 31)
                idle_sender($urandom_range(1, 3));
            add_pct = ((n / 16) % 2 == 0) ? 75 : 35;
            if ($urandom_range(0, 99) < add_pct)
                send_request(REQ_ADD, 16'($urandom), 2'($urandom), pick_burst());
            else
                send_request(REQ_RUN, 16'($urandom), 2'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        req_type    = REQ_ADD;
        process_id  = '0;
        start_level = '0;
        burst_time  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: write_all_quanta(16'hffff, 16'hffff, 16'hffff, 16'hffff);
                1: write_all_quanta(16'h0001, 16'h0001, 16'h0001, 16'h0001);
                // zero quantum demotes without taking any time off
                2: write_all_quanta(16'h0000, 16'h0002, 16'h0000, 16'h0005);
                3: write_all_quanta(16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
                                    16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)));
                4: write_all_quanta(16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)));
                default: write_all_quanta(16'h0001, 16'h0002, 16'h0004, 16'h0008);
            endcase
            // phase 1 runs with no sender gaps at all
            run_random_phase(ph, ph == 1);
        end

        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== multilevel_feedback_queue_scheduler_top.f =====
src/mfqs_pkg.sv
src/mfqs_regs.sv
src/mfqs_ctrl.sv
src/mfqs_datapath.sv
src/multilevel_feedback_queue_scheduler_top.sv
verif/testbench.sv
